FILE: src/ledfe_pkg.sv
`timescale 1ns / 1ps
// ledfe_pkg: shared types and constants of the LED frame encoder.
// No dependencies; every module file imports it.
package ledfe_pkg;

  localparam int unsigned DUTY_W       = 16;
  localparam int unsigned COLOR_W      = 24;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned INDEX_W      = 8;
  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned BIT_W        = 5;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CMD_DEPTH    = 2;

  // request codes on the input word
  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_FILL  = 3'd1,
    REQ_START = 3'd2,
    REQ_SLOT  = 3'd3,
    REQ_TICK  = 3'd4
  } req_e;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_BAD_INDEX,
    OP_FILL,
    OP_START,
    OP_SLOT,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE          = 2'd0,
    ST_START_IGNORED = 2'd1,
    ST_BAD_INDEX     = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_DUTY   = 3'd0,
    CFG_ZERO_DUTY  = 3'd1,
    CFG_RESET_SLOT = 3'd2,
    CFG_TIMEOUT    = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [INDEX_W-1:0] led_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              frame_last;
    logic              busy_res;
    status_e           status;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DUTY_W-1:0]    value;
  } cfg_wr_t;

  typedef struct packed {
    logic [DUTY_W-1:0] one_duty;
    logic [DUTY_W-1:0] zero_duty;
    logic [7:0]        reset_slot_count;
    logic [7:0]        timeout_ms;
  } cfg_regs_t;

  typedef struct packed {
    op_e                op;
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] grb;
  } cmd_t;

endpackage

FILE: src/ledfe_stream_if.sv
`timescale 1ns / 1ps
// ledfe_stream_if: valid/ready channel carrying one word of type T.
// Used for the item, result and configuration channels; payload types in ledfe_pkg.
interface ledfe_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ledfe_front.sv
`timescale 1ns / 1ps
// ledfe_front: decodes input words into commands (range check, GRB packing).
// Depends on ledfe_pkg and ledfe_stream_if.
module ledfe_front #(
  parameter int unsigned LED_COUNT = 64
) (
  ledfe_stream_if.sink     item_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output ledfe_pkg::cmd_t  push_data_o
);
  import ledfe_pkg::*;

  item_t it;

  always_comb begin
    it                     = item_i.data;
    item_i.ready           = push_ready_i;
    push_valid_o           = item_i.valid;
    push_data_o.led_index  = it.led_index;
    push_data_o.grb        = {it.green, it.red, it.blue};
    unique case (it.req_type)
      REQ_WRITE: begin
        if (it.led_index < INDEX_W'(LED_COUNT)) begin
          push_data_o.op = OP_WRITE;
        end else begin
          push_data_o.op = OP_BAD_INDEX;
        end
      end
      REQ_FILL:  push_data_o.op = OP_FILL;
      REQ_START: push_data_o.op = OP_START;
      REQ_SLOT:  push_data_o.op = OP_SLOT;
      REQ_TICK:  push_data_o.op = OP_TICK;
      default:   push_data_o.op = OP_NOP;
    endcase
  end

endmodule

FILE: src/ledfe_cmd_fifo.sv
`timescale 1ns / 1ps
// ledfe_cmd_fifo: short command queue between front and back.
// Depends on ledfe_pkg (cmd_t, CMD_DEPTH).
module ledfe_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  ledfe_pkg::cmd_t  push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output ledfe_pkg::cmd_t  pop_data_o
);
  import ledfe_pkg::*;

  localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             entry_q [CMD_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  always_comb begin
    push_ready_o = (cnt_q != CNT_W'(CMD_DEPTH));
    pop_valid_o  = (cnt_q != '0);
    pop_data_o   = entry_q[rptr_q];
    push         = push_valid_i && push_ready_o;
    pop          = pop_valid_o && pop_ready_i;
    wptr_d       = push ? wptr_q + PTR_W'(1) : wptr_q;
    rptr_d       = pop ? rptr_q + PTR_W'(1) : rptr_q;
    cnt_d        = cnt_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/ledfe_back.sv
`timescale 1ns / 1ps
// ledfe_back: executes commands; color store banks, frame snapshot, slot sequencer
// and result register. Depends on ledfe_pkg and ledfe_stream_if.
module ledfe_back #(
  parameter int unsigned LED_COUNT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ledfe_pkg::cfg_regs_t regs_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  ledfe_pkg::cmd_t     pop_data_i,
  ledfe_stream_if.source      result_o
);
  import ledfe_pkg::*;

  localparam int unsigned IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned CW = $clog2(LED_COUNT + 1);
  localparam logic [IW-1:0]    LAST_LED = IW'(LED_COUNT - 1);
  localparam logic [BIT_W-1:0] TOP_BIT  = BIT_W'(BITS_PER_LED - 1);

  // two banks; an entry lives in bank bank_q[i] when wr_q[i] is set, else it is fill_q
  logic [COLOR_W-1:0] mem_a [LED_COUNT];
  logic [COLOR_W-1:0] mem_b [LED_COUNT];
  logic [COLOR_W-1:0] rd_a_q, rd_b_q;

  logic [LED_COUNT-1:0] wr_q, wr_d, bank_q, bank_d;
  logic [LED_COUNT-1:0] snap_wr_q, snap_wr_d, snap_bank_q, snap_bank_d;
  logic [COLOR_W-1:0]   fill_q, fill_d, snap_fill_q, snap_fill_d;

  logic             sending_q, sending_d;
  logic             tail_q, tail_d;
  logic [IW-1:0]    led_q, led_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic [7:0]       tail_cnt_q, tail_cnt_d;
  logic [7:0]       elapsed_q, elapsed_d;

  // word prefetch: read issue, one pending read, two-word buffer
  logic [CW-1:0]      fetch_led_q, fetch_led_d;
  logic               rd_pend_q, rd_pend_d;
  logic [IW-1:0]      rd_led_q, rd_led_d;
  logic [COLOR_W-1:0] word0_q, word0_d, word1_q, word1_d;
  logic [1:0]         word_cnt_q, word_cnt_d;

  logic    out_vld_q, out_vld_d;
  result_t out_q, out_d;

  cmd_t               hd;
  logic               out_free, data_phase, stall, exec, start_go, pop_word, rd_en;
  logic               mem_we, mem_wsel, is_last;
  logic [IW-1:0]      widx, fetch_idx;
  logic [COLOR_W-1:0] push_word;
  result_t            res;

  always_comb begin
    hd         = pop_data_i;
    out_free   = !out_vld_q || result_o.ready;
    data_phase = sending_q && !tail_q;
    stall      = (hd.op == OP_SLOT) && data_phase && (word_cnt_q == 2'd0);
    exec       = pop_valid_i && out_free && !stall;
    start_go   = exec && (hd.op == OP_START) &&
                 !(sending_q && (elapsed_q <= regs_i.timeout_ms));
    widx       = hd.led_index[IW-1:0];
    fetch_idx  = fetch_led_q[IW-1:0];
    pop_word   = exec && (hd.op == OP_SLOT) && data_phase && (bit_q == '0);
    rd_en      = sending_q && !start_go && (fetch_led_q < CW'(LED_COUNT)) &&
                 (({1'b0, word_cnt_q} + {2'b00, rd_pend_q}) < 3'd2);

    sending_d   = sending_q;
    tail_d      = tail_q;
    led_d       = led_q;
    bit_d       = bit_q;
    tail_cnt_d  = tail_cnt_q;
    elapsed_d   = elapsed_q;
    wr_d        = wr_q;
    bank_d      = bank_q;
    fill_d      = fill_q;
    snap_wr_d   = snap_wr_q;
    snap_bank_d = snap_bank_q;
    snap_fill_d = snap_fill_q;
    mem_we      = 1'b0;
    mem_wsel    = 1'b0;
    is_last     = 1'b0;
    res         = '{duty: '0, frame_last: 1'b0, busy_res: 1'b0, status: ST_DONE};

    // prefetch path
    push_word   = snap_wr_q[rd_led_q] ? (snap_bank_q[rd_led_q] ? rd_b_q : rd_a_q)
                                      : snap_fill_q;
    rd_pend_d   = rd_en;
    rd_led_d    = rd_en ? fetch_idx : rd_led_q;
    fetch_led_d = rd_en ? fetch_led_q + CW'(1) : fetch_led_q;
    word0_d     = word0_q;
    word1_d     = word1_q;
    word_cnt_d  = word_cnt_q;
    unique case ({pop_word, rd_pend_q})
      2'b11: begin
        if (word_cnt_q == 2'd1) begin
          word0_d = push_word;
        end else begin
          word0_d = word1_q;
          word1_d = push_word;
        end
      end
      2'b10: begin
        word0_d    = word1_q;
        word_cnt_d = word_cnt_q - 2'd1;
      end
      2'b01: begin
        if (word_cnt_q == 2'd0) begin
          word0_d = push_word;
        end else begin
          word1_d = push_word;
        end
        word_cnt_d = word_cnt_q + 2'd1;
      end
      default: ;
    endcase

    if (exec) begin
      unique case (hd.op)
        OP_WRITE: begin
          mem_we       = 1'b1;
          // during a frame keep the snapshot entry intact: write the other bank
          mem_wsel     = sending_q ? !snap_bank_q[widx] : bank_q[widx];
          wr_d[widx]   = 1'b1;
          bank_d[widx] = mem_wsel;
        end
        OP_BAD_INDEX: res.status = ST_BAD_INDEX;
        OP_FILL: begin
          wr_d   = '0;
          fill_d = hd.grb;
        end
        OP_START: begin
          if (start_go) begin
            snap_wr_d   = wr_q;
            snap_bank_d = bank_q;
            snap_fill_d = fill_q;
            sending_d   = 1'b1;
            tail_d      = 1'b0;
            led_d       = '0;
            bit_d       = TOP_BIT;
            tail_cnt_d  = '0;
            elapsed_d   = '0;
            fetch_led_d = '0;
            rd_pend_d   = 1'b0;
            word_cnt_d  = '0;
          end else begin
            res.status = ST_START_IGNORED;
          end
        end
        OP_SLOT: begin
          if (sending_q) begin
            if (!tail_q) begin
              res.duty = word0_q[bit_q] ? regs_i.one_duty : regs_i.zero_duty;
              if (bit_q == '0) begin
                bit_d = TOP_BIT;
                led_d = led_q + IW'(1);
                if (led_q == LAST_LED) begin
                  tail_d     = 1'b1;
                  tail_cnt_d = '0;
                  is_last    = (regs_i.reset_slot_count == 8'd0);
                end
              end else begin
                bit_d = bit_q - BIT_W'(1);
              end
            end else begin
              is_last    = (({1'b0, tail_cnt_q} + 9'd1) >= {1'b0, regs_i.reset_slot_count});
              tail_cnt_d = tail_cnt_q + 8'd1;
            end
            if (is_last) begin
              sending_d  = 1'b0;
              tail_d     = 1'b0;
              elapsed_d  = '0;
              rd_pend_d  = 1'b0;
              word_cnt_d = '0;
            end
          end
        end
        OP_TICK: begin
          if (sending_q && (elapsed_q != 8'hFF)) begin
            elapsed_d = elapsed_q + 8'd1;
          end
        end
        default: ;
      endcase
    end

    res.frame_last = is_last;
    res.busy_res   = sending_d || is_last;

    pop_ready_o = exec;
    out_vld_d   = exec ? 1'b1 : (result_o.ready ? 1'b0 : out_vld_q);
    out_d       = exec ? res : out_q;

    result_o.valid = out_vld_q;
    result_o.data  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q   <= 1'b0;
      tail_q      <= 1'b0;
      led_q       <= '0;
      bit_q       <= '0;
      tail_cnt_q  <= '0;
      elapsed_q   <= '0;
      wr_q        <= '0;
      bank_q      <= '0;
      fill_q      <= '0;
      snap_wr_q   <= '0;
      snap_bank_q <= '0;
      snap_fill_q <= '0;
      fetch_led_q <= '0;
      rd_pend_q   <= 1'b0;
      rd_led_q    <= '0;
      word_cnt_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      sending_q   <= sending_d;
      tail_q      <= tail_d;
      led_q       <= led_d;
      bit_q       <= bit_d;
      tail_cnt_q  <= tail_cnt_d;
      elapsed_q   <= elapsed_d;
      wr_q        <= wr_d;
      bank_q      <= bank_d;
      fill_q      <= fill_d;
      snap_wr_q   <= snap_wr_d;
      snap_bank_q <= snap_bank_d;
      snap_fill_q <= snap_fill_d;
      fetch_led_q <= fetch_led_d;
      rd_pend_q   <= rd_pend_d;
      rd_led_q    <= rd_led_d;
      word_cnt_q  <= word_cnt_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word0_q <= word0_d;
    word1_q <= word1_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && !mem_wsel) begin
      mem_a[widx] <= hd.grb;
    end
    if (rd_en) begin
      rd_a_q <= mem_a[fetch_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && mem_wsel) begin
      mem_b[widx] <= hd.grb;
    end
    if (rd_en) begin
      rd_b_q <= mem_b[fetch_idx];
    end
  end

  a_word_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, word_cnt_q} + {2'b00, rd_pend_q}) <= 3'd2)
    else $error("prefetch buffer overrun");

  a_fetch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_led_q <= CW'(LED_COUNT))
    else $error("fetch pointer past last LED");

  a_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_go |=> sending_q && !tail_q && (led_q == '0) && (bit_q == TOP_BIT) &&
                 (word_cnt_q == 2'd0) && !rd_pend_q)
    else $error("frame start did not reset the sequencer");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.frame_last) |-> (out_q.busy_res && !sending_q))
    else $error("frame end word while still sending");

  a_elapsed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elapsed_q != 8'd0) |-> sending_q)
    else $error("busy time counted while idle");

endmodule

FILE: src/addressable_led_frame_encoder.sv
`timescale 1ns / 1ps
// addressable_led_frame_encoder: top level; config registers, front decode,
// command queue and back end. Depends on ledfe_pkg, ledfe_stream_if and all ledfe_* modules.

// Serial LED frame encoder (GRB, MSB first, one PWM compare value per slot).
// Every input word yields exactly one result word, in order. Words are taken
// at one per cycle while the queue has room: the front decodes a word in the
// cycle it is accepted and queues it in a two-entry command queue; the back
// executes one command per cycle into a result register, so a result passes
// through the queue entry and then the result register. While a result waits
// to be taken the queue soaks up words until it holds two, then the input
// stalls. The one exception is a slot request right after a frame start: the
// back holds it while the first LED's color is read from the frame bank memory
// into a read register and then loaded into the word buffer; later LED colors
// are prefetched into that two-word buffer, so data slots then run one per cycle.
// A single-LED write or a fill is handled by one command: fills are kept as a
// fill color plus a per-LED written flag, and the frame copy is a snapshot of
// those flags, the fill color and a per-LED bank select over two LED_COUNT x 24
// memories, so a frame start is also one command and no clearing pass runs
// after reset. Writes made while a frame is out land in the bank the frame
// is not reading. Config writes take effect at once and are always accepted.
module addressable_led_frame_encoder #(
  parameter int unsigned LED_COUNT = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ledfe_stream_if.sink   cfg_i,
  ledfe_stream_if.sink   item_i,
  ledfe_stream_if.source result_o
);
  import ledfe_pkg::*;

  cfg_regs_t regs_q, regs_d;
  cfg_wr_t   cw;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  // config registers; an index past the list is accepted and dropped
  always_comb begin
    cw          = cfg_i.data;
    cfg_i.ready = 1'b1;
    regs_d      = regs_q;
    if (cfg_i.valid) begin
      unique case (cw.index)
        CFG_ONE_DUTY:   regs_d.one_duty         = cw.value;
        CFG_ZERO_DUTY:  regs_d.zero_duty        = cw.value;
        CFG_RESET_SLOT: regs_d.reset_slot_count = cw.value[7:0];
        CFG_TIMEOUT:    regs_d.timeout_ms       = cw.value[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.one_duty         <= 16'd58;
      regs_q.zero_duty        <= 16'd29;
      regs_q.reset_slot_count <= 8'd50;
      regs_q.timeout_ms       <= 8'd5;
    end else begin
      regs_q <= regs_d;
    end
  end

  ledfe_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ledfe_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ledfe_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .regs_i      (regs_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .result_o    (result_o)
  );

endmodule
